### design/dsa_pkg.sv
package dsa_pkg;

	localparam int WORD_BITS = 32;

	localparam logic [2:0] MODE_ONE       = 3'd0;
	localparam logic [2:0] MODE_BATCH     = 3'd1;
	localparam logic [2:0] MODE_RANGE     = 3'd2;
	localparam logic [2:0] MODE_FREE      = 3'd3;
	localparam logic [2:0] MODE_FREE_ADDR = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_NORUN    = 3'd2;
	localparam logic [2:0] ST_MISALIGN = 3'd3;
	localparam logic [2:0] ST_OUTSIDE  = 3'd4;

	localparam logic [2:0] CFG_SLOTS  = 3'd0;
	localparam logic [2:0] CFG_STRIDE = 3'd1;
	localparam logic [2:0] CFG_CPU    = 3'd2;
	localparam logic [2:0] CFG_VIS    = 3'd3;
	localparam logic [2:0] CFG_GPU    = 3'd4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [10:0] count;
		logic [9:0]  slot;
		logic [63:0] address;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot_index;
		logic [63:0] cpu_address;
		logic [63:0] gpu_address;
		logic [10:0] range_length;
		logic [10:0] free_total;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  status;
		logic [9:0]  slot;
		logic        alloc;
		logic [10:0] range_length;
		logic [10:0] free_total;
		logic        last;
	} emit_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_A_RD, S_A_LD, S_A_POP, S_R_RD, S_R_LD, S_R_BIT,
		S_C_RD, S_C_WR, S_F_RD, S_F_WR, S_D_START, S_DIV, S_D_END
	} state_t;

endpackage

### design/descriptor_slot_allocator.sv
// Descriptor slot allocator. The free map is held in a 32-bit wide RAM, one bit per slot,
// and is rebuilt by a sweep of one word per cycle after reset and after every write of
// CFG_SLOTS; busy is high during the sweep. A command word is taken when start is high
// and busy low. Single allocation scans one word per cycle for the first word with a free
// bit; a batch hands out slots from it in turn and scans on once that word is used up. A
// contiguous range is searched one slot per cycle from slot zero, pausing to read each
// new word, and the run found is then cleared word by word. Freeing by index reads the
// word and sets the slot's bit; freeing by address first runs a 64-step restoring divider
// by the stride, unless the stride is zero. Each result word appears on result for one
// cycle with result_valid, after the em_s1, em_s2 and output registers of dsa_addr_pipe;
// the receiver cannot stall it, and a batch can deliver one word every cycle while the
// held word has free slots. Commands rejected in the idle state give their single result
// straight away, others after their search or division; modes 5 to 7 give none.
module descriptor_slot_allocator #(
	parameter int NUM_SLOTS = 1024,
	parameter int MAX_BATCH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dsa_pkg::item_t    item,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output logic              result_valid,
	output dsa_pkg::result_t  result
);

	// Slot indices are ten bits wide, so the heap never exceeds 1024 slots.
	localparam int HEAP_MAX = NUM_SLOTS < 1024 ? NUM_SLOTS : 1024;
	localparam int WORDS    = (HEAP_MAX + dsa_pkg::WORD_BITS - 1) / dsa_pkg::WORD_BITS;
	localparam int WAW      = WORDS > 1 ? $clog2(WORDS) : 1;
	localparam logic [10:0] HEAP_CAP = 11'(HEAP_MAX);
	localparam logic [10:0] BATCH_CAP = 11'(MAX_BATCH);

	dsa_pkg::state_t st_q, st_d;
	logic [WAW-1:0]  wp_q, wp_d;
	logic [31:0]     wd_q, wd_d;
	logic [10:0]     sc_q, sc_d;
	logic [10:0]     run_q, run_d;
	logic [6:0]      rem_q, rem_d;
	logic [10:0]     cnt_q, cnt_d;
	logic [9:0]      start_q, start_d;
	logic [9:0]      fs_q, fs_d;
	logic [63:0]     off_q, off_d;
	logic [10:0]     dr_q, dr_d;
	logic [5:0]      dc_q, dc_d;
	logic [10:0]     stride_q, stride_d;
	logic [63:0]     cpu_q, cpu_d;
	logic [63:0]     gpu_q, gpu_d;
	logic            vis_q, vis_d;
	logic [10:0]     heap_q, heap_d;
	logic [10:0]     fc_q, fc_d;

	logic            ram_we;
	logic [WAW-1:0]  ram_waddr;
	logic [31:0]     ram_wdata;
	logic [WAW-1:0]  ram_raddr;
	logic [31:0]     ram_rdata;

	dsa_pkg::emit_t  em;

	logic [31:0]     init_word;
	logic [31:0]     clr_mask;
	logic [4:0]      low_bit;
	logic [31:0]     pop_word;
	logic [10:0]     range_end;
	logic [10:0]     run_next;
	logic [11:0]     div_r;
	logic            div_ge;
	logic [10:0]     new_heap;

	dsa_ram #(.WIDTH(dsa_pkg::WORD_BITS), .DEPTH(WORDS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dsa_addr_pipe u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.em           (em),
		.stride       (stride_q),
		.cpu_base     (cpu_q),
		.gpu_base     (gpu_q),
		.gpu_visible  (vis_q),
		.result_valid (result_valid),
		.result       (result)
	);

	assign busy      = st_q != dsa_pkg::S_IDLE;
	assign range_end = 11'(start_q) + cnt_q - 11'd1;
	assign run_next  = wd_q[sc_q[4:0]] ? run_q + 11'd1 : 11'd0;
	assign div_r     = {dr_q, off_q[63]};
	assign div_ge    = div_r >= {1'b0, stride_q};
	assign pop_word  = wd_q & ~(32'd1 << low_bit);
	assign new_heap  = cfg_data[10:0] > HEAP_CAP ? HEAP_CAP : cfg_data[10:0];

	// Per-bit masks for the rebuild sweep and for clearing an allocated range.
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			init_word[b] = (int'(wp_q) * 32 + b) < int'(heap_q);
			clr_mask[b]  = (int'(wp_q) * 32 + b) >= int'(start_q) &&
				(int'(wp_q) * 32 + b) <= int'(range_end);
		end
	end

	// Lowest set bit of the held word.
	always_comb begin
		low_bit = '0;
		for (int b = 31; b >= 0; b--) begin
			if (wd_q[b]) begin
				low_bit = 5'(b);
			end
		end
	end

	always_comb begin
		st_d     = st_q;
		wp_d     = wp_q;
		wd_d     = wd_q;
		sc_d     = sc_q;
		run_d    = run_q;
		rem_d    = rem_q;
		cnt_d    = cnt_q;
		start_d  = start_q;
		fs_d     = fs_q;
		off_d    = off_q;
		dr_d     = dr_q;
		dc_d     = dc_q;
		stride_d = stride_q;
		cpu_d    = cpu_q;
		gpu_d    = gpu_q;
		vis_d    = vis_q;
		heap_d   = heap_q;
		fc_d     = fc_q;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = '0;
		ram_raddr = wp_q;
		em            = '0;
		em.last       = 1'b1;
		em.free_total = fc_q;

		case (st_q)
			dsa_pkg::S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = init_word;
				if (int'(wp_q) == WORDS - 1) begin
					wp_d = '0;
					st_d = dsa_pkg::S_IDLE;
				end else begin
					wp_d = wp_q + 1'b1;
				end
			end
			dsa_pkg::S_IDLE: begin
				if (start) begin
					case (item.mode)
						dsa_pkg::MODE_ONE: begin
							if (fc_q == '0) begin
								em.valid  = 1'b1;
								em.status = dsa_pkg::ST_SHORT;
							end else begin
								fc_d  = fc_q - 11'd1;
								rem_d = 7'd1;
								wp_d  = '0;
								st_d  = dsa_pkg::S_A_RD;
							end
						end
						dsa_pkg::MODE_BATCH: begin
							if (item.count > BATCH_CAP || item.count > fc_q) begin
								em.valid  = 1'b1;
								em.status = dsa_pkg::ST_SHORT;
							end else if (item.count == '0) begin
								em.valid  = 1'b1;
								em.status = dsa_pkg::ST_OK;
							end else begin
								fc_d  = fc_q - item.count;
								rem_d = item.count[6:0];
								wp_d  = '0;
								st_d  = dsa_pkg::S_A_RD;
							end
						end
						dsa_pkg::MODE_RANGE: begin
							if (item.count > fc_q) begin
								em.valid  = 1'b1;
								em.status = dsa_pkg::ST_SHORT;
							end else if (item.count == '0) begin
								em.valid  = 1'b1;
								em.status = dsa_pkg::ST_NORUN;
							end else begin
								cnt_d = item.count;
								wp_d  = '0;
								sc_d  = '0;
								run_d = '0;
								st_d  = dsa_pkg::S_R_RD;
							end
						end
						dsa_pkg::MODE_FREE: begin
							if ({1'b0, item.slot} >= heap_q) begin
								em.valid  = 1'b1;
								em.status = dsa_pkg::ST_OUTSIDE;
							end else begin
								fs_d = item.slot;
								st_d = dsa_pkg::S_F_RD;
							end
						end
						dsa_pkg::MODE_FREE_ADDR: begin
							off_d = item.address - cpu_q;
							st_d  = dsa_pkg::S_D_START;
						end
						default: begin
						end
					endcase
				end
			end
			dsa_pkg::S_A_RD: begin
				st_d = dsa_pkg::S_A_LD;
			end
			dsa_pkg::S_A_LD: begin
				if (ram_rdata == '0) begin
					wp_d      = wp_q + 1'b1;
					ram_raddr = wp_q + 1'b1;
				end else begin
					wd_d = ram_rdata;
					st_d = dsa_pkg::S_A_POP;
				end
			end
			dsa_pkg::S_A_POP: begin
				em.valid  = 1'b1;
				em.status = dsa_pkg::ST_OK;
				em.slot   = 10'((11'(wp_q) << 5) | 11'(low_bit));
				em.alloc  = 1'b1;
				em.last   = rem_q == 7'd1;
				rem_d     = rem_q - 7'd1;
				wd_d      = pop_word;
				if (rem_q == 7'd1 || pop_word == '0) begin
					ram_we    = 1'b1;
					ram_wdata = pop_word;
					if (rem_q == 7'd1) begin
						st_d = dsa_pkg::S_IDLE;
					end else begin
						wp_d = wp_q + 1'b1;
						st_d = dsa_pkg::S_A_RD;
					end
				end
			end
			dsa_pkg::S_R_RD: begin
				st_d = dsa_pkg::S_R_LD;
			end
			dsa_pkg::S_R_LD: begin
				wd_d = ram_rdata;
				st_d = dsa_pkg::S_R_BIT;
			end
			dsa_pkg::S_R_BIT: begin
				if (sc_q >= heap_q) begin
					em.valid  = 1'b1;
					em.status = dsa_pkg::ST_NORUN;
					st_d      = dsa_pkg::S_IDLE;
				end else if (run_next == cnt_q) begin
					start_d = 10'(sc_q + 11'd1 - cnt_q);
					wp_d    = WAW'(10'(sc_q + 11'd1 - cnt_q) >> 5);
					st_d    = dsa_pkg::S_C_RD;
				end else begin
					run_d = run_next;
					sc_d  = sc_q + 11'd1;
					if (sc_q[4:0] == 5'd31) begin
						wp_d = WAW'((sc_q + 11'd1) >> 5);
						st_d = dsa_pkg::S_R_RD;
					end
				end
			end
			dsa_pkg::S_C_RD: begin
				st_d = dsa_pkg::S_C_WR;
			end
			dsa_pkg::S_C_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~clr_mask;
				if (wp_q == WAW'(range_end >> 5)) begin
					fc_d            = fc_q - cnt_q;
					em.valid        = 1'b1;
					em.status       = dsa_pkg::ST_OK;
					em.slot         = start_q;
					em.alloc        = 1'b1;
					em.range_length = cnt_q;
					em.free_total   = fc_q - cnt_q;
					st_d            = dsa_pkg::S_IDLE;
				end else begin
					wp_d = wp_q + 1'b1;
					st_d = dsa_pkg::S_C_RD;
				end
			end
			dsa_pkg::S_F_RD: begin
				ram_raddr = WAW'(fs_q >> 5);
				st_d      = dsa_pkg::S_F_WR;
			end
			dsa_pkg::S_F_WR: begin
				ram_waddr = WAW'(fs_q >> 5);
				em.valid  = 1'b1;
				em.status = dsa_pkg::ST_OK;
				em.slot   = fs_q;
				if (!ram_rdata[fs_q[4:0]]) begin
					ram_we        = 1'b1;
					ram_wdata     = ram_rdata | (32'd1 << fs_q[4:0]);
					fc_d          = fc_q + 11'd1;
					em.free_total = fc_q + 11'd1;
				end
				st_d = dsa_pkg::S_IDLE;
			end
			dsa_pkg::S_D_START: begin
				if (stride_q == '0) begin
					if (off_q != '0 || heap_q == '0) begin
						em.valid  = 1'b1;
						em.status = dsa_pkg::ST_OUTSIDE;
						st_d      = dsa_pkg::S_IDLE;
					end else begin
						fs_d = '0;
						st_d = dsa_pkg::S_F_RD;
					end
				end else begin
					dr_d = '0;
					dc_d = '0;
					st_d = dsa_pkg::S_DIV;
				end
			end
			dsa_pkg::S_DIV: begin
				// Restoring division: one quotient bit per cycle, shifted in below.
				dr_d  = div_ge ? 11'(div_r - {1'b0, stride_q}) : 11'(div_r);
				off_d = {off_q[62:0], div_ge};
				dc_d  = dc_q + 6'd1;
				if (dc_q == 6'd63) begin
					st_d = dsa_pkg::S_D_END;
				end
			end
			dsa_pkg::S_D_END: begin
				if (dr_q != '0) begin
					em.valid  = 1'b1;
					em.status = dsa_pkg::ST_MISALIGN;
					st_d      = dsa_pkg::S_IDLE;
				end else if (off_q[63:11] != '0 || off_q[10:0] >= heap_q) begin
					em.valid  = 1'b1;
					em.status = dsa_pkg::ST_OUTSIDE;
					st_d      = dsa_pkg::S_IDLE;
				end else begin
					fs_d = off_q[9:0];
					st_d = dsa_pkg::S_F_RD;
				end
			end
			default: begin
				st_d = dsa_pkg::S_IDLE;
			end
		endcase

		if (cfg_we) begin
			case (cfg_index)
				dsa_pkg::CFG_SLOTS: begin
					heap_d = new_heap;
					fc_d   = new_heap;
					wp_d   = '0;
					st_d   = dsa_pkg::S_INIT;
				end
				dsa_pkg::CFG_STRIDE: stride_d = cfg_data[10:0];
				dsa_pkg::CFG_CPU:    cpu_d    = cfg_data;
				dsa_pkg::CFG_VIS:    vis_d    = cfg_data[0];
				dsa_pkg::CFG_GPU:    gpu_d    = cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= dsa_pkg::S_INIT;
			wp_q     <= '0;
			rem_q    <= '0;
			stride_q <= 11'd32;
			cpu_q    <= '0;
			gpu_q    <= '0;
			vis_q    <= 1'b0;
			heap_q   <= HEAP_CAP;
			fc_q     <= HEAP_CAP;
		end else begin
			st_q     <= st_d;
			wp_q     <= wp_d;
			rem_q    <= rem_d;
			stride_q <= stride_d;
			cpu_q    <= cpu_d;
			gpu_q    <= gpu_d;
			vis_q    <= vis_d;
			heap_q   <= heap_d;
			fc_q     <= fc_d;
		end
	end

	always_ff @(posedge clk) begin
		wd_q    <= wd_d;
		sc_q    <= sc_d;
		run_q   <= run_d;
		cnt_q   <= cnt_d;
		start_q <= start_d;
		fs_q    <= fs_d;
		off_q   <= off_d;
		dr_q    <= dr_d;
		dc_q    <= dc_d;
	end

`ifndef SYNTH
	// The free count can never exceed the number of slots in the heap.
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= heap_q) else $error("free count above heap size");

	// A pop is only made from a word that still holds a free slot.
	a_pop_word: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == dsa_pkg::S_A_POP |-> wd_q != '0) else $error("pop from empty word");

	// Rejected commands report no addresses and no range.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != dsa_pkg::ST_OK |->
		result.cpu_address == '0 && result.gpu_address == '0 &&
		result.range_length == '0) else $error("error word carries payload");
`endif

endmodule

### design/dsa_ram.sv
module dsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/dsa_addr_pipe.sv
// Turns a slot into its CPU and GPU addresses: multiply, then add.
module dsa_addr_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  dsa_pkg::emit_t    em,
	input  logic [10:0]       stride,
	input  logic [63:0]       cpu_base,
	input  logic [63:0]       gpu_base,
	input  logic              gpu_visible,
	output logic              result_valid,
	output dsa_pkg::result_t  result
);

	dsa_pkg::emit_t em_s1;
	dsa_pkg::emit_t em_s2;
	logic [20:0]    off_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_s1        <= '0;
			em_s2        <= '0;
			off_s2       <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			em_s1        <= em;
			em_s2        <= em_s1;
			off_s2       <= 21'(em_s1.slot) * 21'(stride);
			result_valid <= em_s2.valid;
			result.status       <= em_s2.status;
			result.slot_index   <= em_s2.slot;
			result.cpu_address  <= em_s2.alloc ? cpu_base + 64'(off_s2) : '0;
			result.gpu_address  <= (em_s2.alloc && gpu_visible) ?
				gpu_base + 64'(off_s2) : '0;
			result.range_length <= em_s2.range_length;
			result.free_total   <= em_s2.free_total;
			result.last         <= em_s2.last;
		end
	end

endmodule
